// ----- rtl/pbm_pkg.sv -----
package pbm_pkg;

    localparam int DIM_BITS       = 16;
    localparam int DEC_DIGITS     = ((DIM_BITS * 1233) >> 12) + 1;
    localparam int BCD_BITS       = DEC_DIGITS * 4;
    localparam int CONV_CNT_BITS  = $clog2(DIM_BITS);
    localparam int DIG_CNT_BITS   = (DEC_DIGITS > 1) ? $clog2(DEC_DIGITS) : 1;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    localparam logic [7:0] CHAR_P    = 8'h50;
    localparam logic [7:0] CHAR_4    = 8'h34;
    localparam logic [7:0] CHAR_NL   = 8'h0a;
    localparam logic [7:0] CHAR_ZERO = 8'h30;

    typedef struct packed {
        logic                header;
        logic                data;
        logic [7:0]          data_byte;
        logic                image_last;
        logic [DIM_BITS-1:0] width;
        logic [DIM_BITS-1:0] height;
    } t_job;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CONV,
        S_MAG_P,
        S_MAG_4,
        S_NL1,
        S_WDIG,
        S_NL2,
        S_HDIG,
        S_NL3,
        S_DATA
    } t_back_state;

    function automatic logic [BCD_BITS-1:0] bcd_adjust(input logic [BCD_BITS-1:0] v);
        logic [BCD_BITS-1:0] r;
        r = v;
        for (int i = 0; i < DEC_DIGITS; i++) begin
            if (v[4*i +: 4] >= 4'd5) begin
                r[4*i +: 4] = v[4*i +: 4] + 4'd3;
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/pbm_front.sv -----
module pbm_front
    import pbm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_pix_valid,
    output logic                o_pix_ready,
    input  logic                i_pixel_bit,
    input  logic [DIM_BITS-1:0] i_image_width,
    input  logic [DIM_BITS-1:0] i_image_height,
    input  logic                i_queue_full,
    output logic                o_job_push,
    output t_job                o_job
);

    logic                r_header_done;
    logic [DIM_BITS-1:0] r_col;
    logic [DIM_BITS-1:0] r_row;
    logic [7:0]          r_pack;

    logic                accept;
    logic [2:0]          pos;
    logic [7:0]          n_pack;
    logic                row_end;
    logic                image_end;
    logic                emit_data;

    assign o_pix_ready = !i_queue_full;
    assign accept      = i_pix_valid && !i_queue_full;
    assign pos         = r_col[2:0];
    assign n_pack      = r_pack | (8'({7'b0, i_pixel_bit}) << (3'd7 - pos));
    assign row_end     = ({1'b0, r_col} + 1'b1) >= {1'b0, i_image_width};
    assign image_end   = row_end && (({1'b0, r_row} + 1'b1) >= {1'b0, i_image_height});
    assign emit_data   = (pos == 3'd7) || row_end;

    assign o_job_push       = accept && (!r_header_done || emit_data);
    assign o_job.header     = !r_header_done;
    assign o_job.data       = emit_data;
    assign o_job.data_byte  = n_pack;
    assign o_job.image_last = image_end;
    assign o_job.width      = i_image_width;
    assign o_job.height     = i_image_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_done <= 1'b0;
            r_col         <= '0;
            r_row         <= '0;
            r_pack        <= '0;
        end else if (accept) begin
            r_header_done <= 1'b1;
            r_pack        <= emit_data ? 8'h00 : n_pack;
            if (row_end) begin
                r_col <= '0;
                if (image_end) begin
                    r_row         <= '0;
                    r_header_done <= 1'b0;
                end else begin
                    r_row <= r_row + 1'b1;
                end
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

endmodule

// ----- rtl/pbm_queue.sv -----
module pbm_queue
    import pbm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    t_job                    r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr_ptr;
    logic [QUEUE_PTR_BITS-1:0] r_rd_ptr;
    logic [QUEUE_PTR_BITS:0]   r_cnt;

    assign o_full  = (r_cnt == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/pbm_back.sv -----
module pbm_back
    import pbm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    input  t_job       i_job,
    output logic       o_job_pop,
    output logic       o_byte_valid,
    input  logic       i_byte_ready,
    output logic [7:0] o_out_byte,
    output logic       o_is_header,
    output logic       o_run_last,
    output logic       o_image_last
);

    t_back_state               r_state;
    t_back_state               n_state;
    t_job                      r_job;
    logic [DIM_BITS-1:0]       r_wbin;
    logic [DIM_BITS-1:0]       r_hbin;
    logic [BCD_BITS-1:0]       r_wbcd;
    logic [BCD_BITS-1:0]       r_hbcd;
    logic [CONV_CNT_BITS-1:0]  r_conv_cnt;
    logic [DIG_CNT_BITS-1:0]   r_dig_cnt;
    logic                      r_started;
    logic                      r_byte_valid;
    logic [7:0]                r_out_byte;
    logic                      r_is_header;
    logic                      r_run_last;
    logic                      r_image_last;

    logic                      slot_free;
    logic                      conv_last;
    logic                      dig_last;
    logic [3:0]                wdig;
    logic [3:0]                hdig;
    logic                      wshow;
    logic                      hshow;
    logic [BCD_BITS-1:0]       wadj;
    logic [BCD_BITS-1:0]       hadj;
    logic                      emit;
    logic                      advance;
    logic                      pop;
    logic [7:0]                emit_byte;
    logic                      emit_hdr;
    logic                      emit_run_last;
    logic                      emit_img_last;

    assign slot_free = !r_byte_valid || i_byte_ready;
    assign conv_last = (r_conv_cnt == CONV_CNT_BITS'(DIM_BITS - 1));
    assign dig_last  = (r_dig_cnt == DIG_CNT_BITS'(DEC_DIGITS - 1));
    assign wdig      = r_wbcd[BCD_BITS-1 -: 4];
    assign hdig      = r_hbcd[BCD_BITS-1 -: 4];
    assign wshow     = r_started || (wdig != 4'd0) || dig_last;
    assign hshow     = r_started || (hdig != 4'd0) || dig_last;
    assign wadj      = bcd_adjust(r_wbcd);
    assign hadj      = bcd_adjust(r_hbcd);
    assign advance   = emit ? slot_free : 1'b1;
    assign o_job_pop = pop;

    always_comb begin
        emit          = 1'b0;
        pop           = 1'b0;
        emit_byte     = CHAR_NL;
        emit_hdr      = 1'b1;
        emit_run_last = 1'b0;
        emit_img_last = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                pop = i_job_valid;
            end
            S_CONV: begin
                emit = 1'b0;
            end
            S_MAG_P: begin
                emit      = 1'b1;
                emit_byte = CHAR_P;
            end
            S_MAG_4: begin
                emit      = 1'b1;
                emit_byte = CHAR_4;
            end
            S_NL1, S_NL2: begin
                emit = 1'b1;
            end
            S_WDIG: begin
                emit      = wshow;
                emit_byte = CHAR_ZERO | {4'b0, wdig};
            end
            S_HDIG: begin
                emit      = hshow;
                emit_byte = CHAR_ZERO | {4'b0, hdig};
            end
            S_NL3: begin
                emit          = 1'b1;
                emit_run_last = !r_job.data;
            end
            S_DATA: begin
                emit          = 1'b1;
                emit_byte     = r_job.data_byte;
                emit_hdr      = 1'b0;
                emit_run_last = 1'b1;
                emit_img_last = r_job.image_last;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_state = i_job.header ? S_CONV : S_DATA;
                end
            end
            S_CONV: begin
                if (conv_last) begin
                    n_state = S_MAG_P;
                end
            end
            S_MAG_P: begin
                if (advance) n_state = S_MAG_4;
            end
            S_MAG_4: begin
                if (advance) n_state = S_NL1;
            end
            S_NL1: begin
                if (advance) n_state = S_WDIG;
            end
            S_WDIG: begin
                if (advance && dig_last) n_state = S_NL2;
            end
            S_NL2: begin
                if (advance) n_state = S_HDIG;
            end
            S_HDIG: begin
                if (advance && dig_last) n_state = S_NL3;
            end
            S_NL3: begin
                if (advance) n_state = r_job.data ? S_DATA : S_IDLE;
            end
            S_DATA: begin
                if (advance) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_conv_cnt   <= '0;
            r_dig_cnt    <= '0;
            r_started    <= 1'b0;
            r_byte_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (pop) begin
                r_conv_cnt <= '0;
                r_dig_cnt  <= '0;
                r_started  <= 1'b0;
            end else if (r_state == S_CONV) begin
                r_conv_cnt <= r_conv_cnt + 1'b1;
            end else if ((r_state == S_WDIG || r_state == S_HDIG) && advance) begin
                if (dig_last) begin
                    r_dig_cnt <= '0;
                    r_started <= 1'b0;
                end else begin
                    r_dig_cnt <= r_dig_cnt + 1'b1;
                    r_started <= r_started || emit;
                end
            end
            if (emit && slot_free) begin
                r_byte_valid <= 1'b1;
            end else if (i_byte_ready) begin
                r_byte_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_job  <= i_job;
            r_wbin <= i_job.width;
            r_hbin <= i_job.height;
            r_wbcd <= '0;
            r_hbcd <= '0;
        end else if (r_state == S_CONV) begin
            r_wbin <= r_wbin << 1;
            r_hbin <= r_hbin << 1;
            r_wbcd <= {wadj[BCD_BITS-2:0], r_wbin[DIM_BITS-1]};
            r_hbcd <= {hadj[BCD_BITS-2:0], r_hbin[DIM_BITS-1]};
        end else if (r_state == S_WDIG && advance) begin
            r_wbcd <= r_wbcd << 4;
        end else if (r_state == S_HDIG && advance) begin
            r_hbcd <= r_hbcd << 4;
        end
        if (emit && slot_free) begin
            r_out_byte   <= emit_byte;
            r_is_header  <= emit_hdr;
            r_run_last   <= emit_run_last;
            r_image_last <= emit_img_last;
        end
    end

    assign o_byte_valid = r_byte_valid;
    assign o_out_byte   = r_out_byte;
    assign o_is_header  = r_is_header;
    assign o_run_last   = r_run_last;
    assign o_image_last = r_image_last;

endmodule

// ----- rtl/pbm_p4_bitmap_encoder_unit.sv -----
// Pixels enter at one per cycle while the four-entry job queue has room.
// With the back end idle a data byte passes from the job queue through the back end's job
// register to the output register; the back end passes its idle and data states per byte.
// The serial back-end sequencer builds a header: it takes the job, runs the binary-to-BCD
// conversion over all DIM_BITS bits, then steps through the header bytes; leading zero
// digits are suppressed but still take a digit step, and output back-pressure stalls bytes.
// Synchronous active-low reset clears counters, queue and output valid; width and height
// reset to 1.
module pbm_p4_bitmap_encoder_unit
    import pbm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [DIM_BITS-1:0] i_cfg_data,
    input  logic                i_pix_valid,
    output logic                o_pix_ready,
    input  logic                i_pixel_bit,
    output logic                o_byte_valid,
    input  logic                i_byte_ready,
    output logic [7:0]          o_out_byte,
    output logic                o_is_header,
    output logic                o_run_last,
    output logic                o_image_last
);

    logic [DIM_BITS-1:0] r_image_width;
    logic [DIM_BITS-1:0] r_image_height;
    logic [DIM_BITS-1:0] cfg_clamped;
    logic                job_push;
    logic                job_pop;
    t_job                front_job;
    t_job                queue_job;
    logic                queue_full;
    logic                queue_empty;

    assign cfg_clamped = (i_cfg_data == '0) ? DIM_BITS'(1) : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= DIM_BITS'(1);
            r_image_height <= DIM_BITS'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_WIDTH:  r_image_width  <= cfg_clamped;
                CFG_IDX_HEIGHT: r_image_height <= cfg_clamped;
                default:        r_image_width  <= r_image_width;
            endcase
        end
    end

    pbm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pix_valid    (i_pix_valid),
        .o_pix_ready    (o_pix_ready),
        .i_pixel_bit    (i_pixel_bit),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .i_queue_full   (queue_full),
        .o_job_push     (job_push),
        .o_job          (front_job)
    );

    pbm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (front_job),
        .i_pop   (job_pop),
        .o_job   (queue_job),
        .o_full  (queue_full),
        .o_empty (queue_empty)
    );

    pbm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (!queue_empty),
        .i_job        (queue_job),
        .o_job_pop    (job_pop),
        .o_byte_valid (o_byte_valid),
        .i_byte_ready (i_byte_ready),
        .o_out_byte   (o_out_byte),
        .o_is_header  (o_is_header),
        .o_run_last   (o_run_last),
        .o_image_last (o_image_last)
    );

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_push |-> !queue_full)
        else $error("job pushed into full queue");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_pop |-> !queue_empty)
        else $error("job popped from empty queue");

    a_image_last_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_byte_valid && o_image_last) |-> (o_run_last && !o_is_header))
        else $error("image end flagged on a header byte or mid-transaction");

endmodule
